// File: hw/rtl/catmull_rom_curve_sampler_macros.svh
// Assertion macros used by the curve sampler top level.
`ifndef CATMULL_ROM_CURVE_SAMPLER_MACROS_SVH
`define CATMULL_ROM_CURVE_SAMPLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/crs_pkg.sv
`default_nettype none

package crs_pkg;

    localparam int SPP_W     = 7;   // samples_per_segment register
    localparam int TSTEP_W   = 16;  // t_step register
    localparam int T_W       = 16;  // t in Q0.16
    localparam int D_W       = 54;  // doubled weight in Q.48, signed
    localparam int W_LSB     = 25;  // doubled Q.48 -> weight Q.24
    localparam int W_W       = D_W - W_LSB;
    localparam int UPC_W     = 4;
    localparam int NUM_LANES = 3;
    localparam int NUM_TAPS  = 4;

    typedef logic [UPC_W-1:0] t_upc;

    typedef enum logic [0:0] {
        REG_SPP   = 1'b0,
        REG_TSTEP = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        COND_NEXT,
        COND_WAIT_IN,
        COND_EMIT,
        COND_JUMP
    } t_cond;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    // One microcode word.
    typedef struct packed {
        t_cond      cond;
        t_upc       target;
        logic       sq_en;
        logic       cube_en;
        logic       w_en;
        logic [1:0] tap;
        logic       mul_en;
        t_acc_op    acc_op;
        logic       emit;
    } t_uword;

    // Sequencer -> datapath controls.
    typedef struct packed {
        logic       sq_en;
        logic       cube_en;
        logic       w_en;
        logic [1:0] tap;
        logic       mul_en;
        t_acc_op    acc_op;
        logic       emit;
    } t_ctl;

    // Datapath -> sequencer status.
    typedef struct packed {
        logic start;
        logic out_free;
        logic last;
    } t_stat;

endpackage

`default_nettype wire

// File: hw/rtl/crs_seq.sv
`default_nettype none

module crs_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  crs_pkg::t_stat i_stat,
    output crs_pkg::t_ctl  o_ctl,
    output logic           o_idle
);
    import crs_pkg::*;

    localparam t_upc S_IDLE = 4'd0;
    localparam t_upc S_SQ   = 4'd1;
    localparam t_upc S_CUBE = 4'd2;
    localparam t_upc S_W0   = 4'd3;
    localparam t_upc S_W1   = 4'd4;
    localparam t_upc S_W2   = 4'd5;
    localparam t_upc S_W3   = 4'd6;
    localparam t_upc S_M0   = 4'd7;
    localparam t_upc S_M1   = 4'd8;
    localparam t_upc S_M2   = 4'd9;
    localparam t_upc S_M3   = 4'd10;
    localparam t_upc S_ACC  = 4'd11;
    localparam t_upc S_EMIT = 4'd12;

    // Microprogram: square, cube, four weights, four multiplies with a
    // trailing accumulate, then emit; loop back or idle at the last.
    function automatic t_uword urom(input t_upc a);
        t_uword w;
        w.cond    = COND_NEXT;
        w.target  = S_IDLE;
        w.sq_en   = 1'b0;
        w.cube_en = 1'b0;
        w.w_en    = 1'b0;
        w.tap     = 2'd0;
        w.mul_en  = 1'b0;
        w.acc_op  = ACC_HOLD;
        w.emit    = 1'b0;
        unique case (a)
            S_IDLE: w.cond = COND_WAIT_IN;
            S_SQ:   w.sq_en = 1'b1;
            S_CUBE: w.cube_en = 1'b1;
            S_W0: begin w.w_en = 1'b1; w.tap = 2'd0; end
            S_W1: begin w.w_en = 1'b1; w.tap = 2'd1; end
            S_W2: begin w.w_en = 1'b1; w.tap = 2'd2; end
            S_W3: begin w.w_en = 1'b1; w.tap = 2'd3; end
            S_M0: begin w.mul_en = 1'b1; w.tap = 2'd0; end
            S_M1: begin w.mul_en = 1'b1; w.tap = 2'd1; w.acc_op = ACC_LOAD; end
            S_M2: begin w.mul_en = 1'b1; w.tap = 2'd2; w.acc_op = ACC_ADD; end
            S_M3: begin w.mul_en = 1'b1; w.tap = 2'd3; w.acc_op = ACC_ADD; end
            S_ACC:  w.acc_op = ACC_ADD;
            S_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = COND_EMIT;
                w.target = S_SQ;
            end
            default: w.cond = COND_JUMP;
        endcase
        return w;
    endfunction

    t_upc   r_pc;
    t_upc   n_pc;
    t_uword uw;

    assign uw = urom(r_pc);

    always_comb begin
        unique case (uw.cond)
            COND_NEXT:    n_pc = r_pc + t_upc'(1);
            COND_WAIT_IN: n_pc = i_stat.start ? r_pc + t_upc'(1) : r_pc;
            COND_EMIT: begin
                if (!i_stat.out_free) n_pc = r_pc;
                else if (i_stat.last) n_pc = S_IDLE;
                else                  n_pc = uw.target;
            end
            COND_JUMP:    n_pc = uw.target;
            default:      n_pc = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_comb begin
        o_ctl.sq_en   = uw.sq_en;
        o_ctl.cube_en = uw.cube_en;
        o_ctl.w_en    = uw.w_en;
        o_ctl.tap     = uw.tap;
        o_ctl.mul_en  = uw.mul_en;
        o_ctl.acc_op  = uw.acc_op;
        o_ctl.emit    = uw.emit & i_stat.out_free;
    end

    assign o_idle = (r_pc == S_IDLE);

endmodule

`default_nettype wire

// File: hw/rtl/crs_dp.sv
`default_nettype none

module crs_dp #(
    parameter int COORD_BITS  = 16,
    parameter int MAX_SAMPLES = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_fire,
    input  logic signed [COORD_BITS-1:0]     i_in_x,
    input  logic signed [COORD_BITS-1:0]     i_in_y,
    input  logic signed [COORD_BITS-1:0]     i_in_z,
    input  logic [crs_pkg::SPP_W-1:0]        i_spp,
    input  logic [crs_pkg::TSTEP_W-1:0]      i_t_step,
    input  crs_pkg::t_ctl                    i_ctl,
    output crs_pkg::t_stat                   o_stat,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [COORD_BITS-1:0]     o_out_x,
    output logic signed [COORD_BITS-1:0]     o_out_y,
    output logic signed [COORD_BITS-1:0]     o_out_z,
    output logic                             o_seg_last
);
    import crs_pkg::*;

    localparam int K_W   = $clog2(MAX_SAMPLES);
    localparam int P_W   = W_W + COORD_BITS;
    localparam int ACC_W = P_W + 2;

    localparam logic signed [D_W-1:0]   D_ONE   = D_W'(64'sd1 <<< (3 * T_W));
    localparam logic signed [D_W-1:0]   D_HALF  = D_W'(64'sd1 <<< (W_LSB - 1));
    localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(64'sd1 <<< 23);
    localparam logic signed [ACC_W-1:0] SAT_HI  =
        ACC_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO  = -SAT_HI - ACC_W'(1);

    logic signed [COORD_BITS-1:0] r_pt [NUM_TAPS][NUM_LANES];
    logic signed [COORD_BITS-1:0] in_pt [NUM_LANES];
    logic [1:0]                   r_seen;
    logic [T_W-1:0]               r_t;
    logic [2*T_W-1:0]             r_t2;
    logic [3*T_W-1:0]             r_t3;
    logic [K_W-1:0]               r_k;
    logic signed [W_W-1:0]        r_w [NUM_TAPS];
    logic signed [P_W-1:0]        r_prod [NUM_LANES];
    logic signed [ACC_W-1:0]      r_acc [NUM_LANES];
    logic signed [ACC_W-1:0]      acc_sh [NUM_LANES];
    logic signed [COORD_BITS-1:0] fin [NUM_LANES];
    logic signed [COORD_BITS-1:0] r_out [NUM_LANES];
    logic                         r_out_valid;
    logic                         r_out_last;
    logic [SPP_W-1:0]             eff_cnt;
    logic                         last;
    logic                         start;
    logic                         out_free;
    logic signed [D_W-1:0]        d_t1;
    logic signed [D_W-1:0]        d_t2;
    logic signed [D_W-1:0]        d_t3;
    logic signed [D_W-1:0]        d_sum;
    logic signed [D_W-1:0]        d_rnd;

    assign in_pt[0] = i_in_x;
    assign in_pt[1] = i_in_y;
    assign in_pt[2] = i_in_z;

    always_comb begin
        eff_cnt = i_spp;
        if (i_spp == '0) begin
            eff_cnt = SPP_W'(1);
        end else if (i_spp > SPP_W'(MAX_SAMPLES)) begin
            eff_cnt = SPP_W'(MAX_SAMPLES);
        end
        last     = ((SPP_W'(r_k) + SPP_W'(1)) == eff_cnt);
        start    = i_in_fire && (r_seen == 2'd3);
        out_free = !r_out_valid || i_out_ready;
    end

    always_comb begin
        o_stat.start    = start;
        o_stat.out_free = out_free;
        o_stat.last     = last;
    end

    // Doubled Catmull-Rom weights in Q.48 from t, t^2, t^3.
    always_comb begin
        d_t3 = $signed({{(D_W-3*T_W){1'b0}}, r_t3});
        d_t2 = $signed({{(D_W-3*T_W){1'b0}}, r_t2, {T_W{1'b0}}});
        d_t1 = $signed({{(D_W-3*T_W){1'b0}}, r_t, {(2*T_W){1'b0}}});
        case (i_ctl.tap)
            2'd0:    d_sum = (d_t2 <<< 1) - d_t3 - d_t1;
            2'd1:    d_sum = (d_t3 <<< 1) + d_t3 - (d_t2 <<< 2) - d_t2 + (D_ONE <<< 1);
            2'd2:    d_sum = (d_t2 <<< 2) - (d_t3 <<< 1) - d_t3 + d_t1;
            default: d_sum = d_t3 - d_t2;
        endcase
        d_rnd = d_sum + D_HALF;
    end

    // Round to Q8.8 and saturate.
    always_comb begin
        for (int c = 0; c < NUM_LANES; c++) begin
            acc_sh[c] = (r_acc[c] + ACC_RND) >>> 24;
            if (acc_sh[c] > SAT_HI) begin
                fin[c] = COORD_BITS'(SAT_HI);
            end else if (acc_sh[c] < SAT_LO) begin
                fin[c] = COORD_BITS'(SAT_LO);
            end else begin
                fin[c] = acc_sh[c][COORD_BITS-1:0];
            end
        end
    end

    // Point window: shift on every accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TAPS; i++) begin
                for (int c = 0; c < NUM_LANES; c++) begin
                    r_pt[i][c] <= '0;
                end
            end
            r_seen <= 2'd0;
        end else if (i_in_fire) begin
            for (int c = 0; c < NUM_LANES; c++) begin
                r_pt[0][c] <= r_pt[1][c];
                r_pt[1][c] <= r_pt[2][c];
                r_pt[2][c] <= r_pt[3][c];
                r_pt[3][c] <= in_pt[c];
            end
            if (r_seen != 2'd3) begin
                r_seen <= r_seen + 2'd1;
            end
        end
    end

    // Sample parameter and index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t <= '0;
            r_k <= '0;
        end else if (start) begin
            r_t <= '0;
            r_k <= '0;
        end else if (i_ctl.emit) begin
            r_t <= r_t + i_t_step;
            r_k <= r_k + K_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sq_en) begin
            r_t2 <= (2*T_W)'(r_t) * (2*T_W)'(r_t);
        end
        if (i_ctl.cube_en) begin
            r_t3 <= (3*T_W)'(r_t2) * (3*T_W)'(r_t);
        end
        if (i_ctl.w_en) begin
            r_w[i_ctl.tap] <= d_rnd[D_W-1:W_LSB];
        end
        for (int c = 0; c < NUM_LANES; c++) begin
            if (i_ctl.mul_en) begin
                r_prod[c] <= P_W'(r_w[i_ctl.tap]) * P_W'(r_pt[i_ctl.tap][c]);
            end
            case (i_ctl.acc_op)
                ACC_LOAD: r_acc[c] <= ACC_W'(r_prod[c]);
                ACC_ADD:  r_acc[c] <= r_acc[c] + ACC_W'(r_prod[c]);
                default:  r_acc[c] <= r_acc[c];
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            for (int c = 0; c < NUM_LANES; c++) begin
                r_out[c] <= fin[c];
            end
            r_out_last <= last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_out[0];
    assign o_out_y     = r_out[1];
    assign o_out_z     = r_out[2];
    assign o_seg_last  = r_out_last;

endmodule

`default_nettype wire

// File: hw/rtl/catmull_rom_curve_sampler.sv
// The request that closes a four-point window starts the microprogram for its first sample.
// Each sample comes from the 12-step microprogram that drives the single datapath, one
//   sample at a time; the emit step waits while the output register still holds a sample.
// A request that does not close a window is taken while idle and yields nothing.
// Reset (synchronous, active low): point window and point count cleared,
//   samples_per_segment = 64, t_step = 1024, sequencer idle, no sample pending.
`default_nettype none
`include "catmull_rom_curve_sampler_macros.svh"

module catmull_rom_curve_sampler #(
    parameter int COORD_BITS  = 16,
    parameter int MAX_SAMPLES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // control point requests
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_BITS-1:0]  i_in_x,
    input  logic signed [COORD_BITS-1:0]  i_in_y,
    input  logic signed [COORD_BITS-1:0]  i_in_z,
    // curve sample requests
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_BITS-1:0]  o_out_x,
    output logic signed [COORD_BITS-1:0]  o_out_y,
    output logic signed [COORD_BITS-1:0]  o_out_z,
    output logic                          o_seg_last,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  crs_pkg::t_reg_idx             i_cfg_index,
    input  logic [crs_pkg::TSTEP_W-1:0]   i_cfg_data
);
    import crs_pkg::*;

    logic [SPP_W-1:0]   r_spp;
    logic [TSTEP_W-1:0] r_t_step;
    logic               in_fire;
    logic               seq_idle;
    t_ctl               ctl;
    t_stat              stat;

    // Configuration is always writable; the register file is tiny.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spp    <= SPP_W'(64);
            r_t_step <= TSTEP_W'(1024);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SPP:   r_spp    <= i_cfg_data[SPP_W-1:0];
                REG_TSTEP: r_t_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Take a point only while the sequencer sits in its idle step. A pending
    // sample in the output register does not block the request.
    assign o_in_ready = seq_idle;
    assign in_fire    = i_in_valid & o_in_ready;

    crs_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .o_idle  (seq_idle)
    );

    // Datapath: point window, t powers, weights, three MAC lanes, output register.
    crs_dp #(
        .COORD_BITS  (COORD_BITS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (in_fire),
        .i_in_x      (i_in_x),
        .i_in_y      (i_in_y),
        .i_in_z      (i_in_z),
        .i_spp       (r_spp),
        .i_t_step    (r_t_step),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_seg_last  (o_seg_last)
    );

    // A window start must leave the idle step at once.
    `CRS_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, stat.start, !o_in_ready)
    // Never overwrite a sample that has not been taken.
    `CRS_ASSERT_NOW(a_emit_free, i_clk, i_rst_n, ctl.emit, !o_out_valid || i_out_ready)
    // The final sample of a window shows seg_last and returns to idle.
    `CRS_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, ctl.emit && stat.last, o_in_ready && o_out_valid && o_seg_last)

endmodule

`default_nettype wire
